// File: rtl/ipff_pkg.sv
package ipff_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;
  localparam int THR_W      = 32;
  localparam int KEY_W      = 32;
  localparam int RES_CNT_W  = 32;

  localparam logic [THR_W-1:0] DROP_THRESHOLD_RST = 32'd20;

  localparam logic [15:0] ETYPE_IPV4      = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP      = 8'd1;
  localparam logic [15:0] LEN_ETH         = 16'd14;
  localparam logic [15:0] LEN_ETH_IP      = 16'd34;
  localparam logic [15:0] LEN_ETH_IP_ICMP = 16'd42;

  localparam logic [2:0] CAUSE_NOT_ICMP   = 3'd0;
  localparam logic [2:0] CAUSE_TRUNCATED  = 3'd1;
  localparam logic [2:0] CAUSE_NEW_SOURCE = 3'd2;
  localparam logic [2:0] CAUSE_TABLE_FULL = 3'd3;
  localparam logic [2:0] CAUSE_UNDER_THR  = 3'd4;
  localparam logic [2:0] CAUSE_OVER_THR   = 3'd5;

  localparam logic VERDICT_PASS = 1'b0;
  localparam logic VERDICT_DROP = 1'b1;

  typedef struct packed {
    logic load;
    logic scan;
    logic hit_upd;
    logic miss;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic early;
    logic match;
    logic issue_ok;
    logic rd_pend;
    logic out_free;
  } status_t;

endpackage

// File: rtl/ipff_ctrl.sv
module ipff_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  ipff_pkg::status_t  status,
  output ipff_pkg::cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_HIT  = 5'b00100,
    S_MISS = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = status.early ? S_EMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.match) begin
          state_nxt = S_HIT;
        end else if (!status.issue_ok && !status.rd_pend) begin
          state_nxt = S_MISS;
        end
      end
      S_HIT: begin
        cmd.hit_upd = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_MISS: begin
        cmd.miss  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/ipff_dp.sv
module ipff_dp #(
  parameter int TABLE_DEPTH = ipff_pkg::TABLE_DEPTH_DEF,
  parameter int COUNT_WIDTH = ipff_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [ipff_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ipff_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [ipff_pkg::THR_W-1:0]      cfg_wdata,
  input  ipff_pkg::cmd_t                  cmd,
  output ipff_pkg::status_t               status
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int USED_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W  = (COUNT_WIDTH > ipff_pkg::THR_W) ? COUNT_WIDTH : ipff_pkg::THR_W;

  logic [ipff_pkg::KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0]     cnt_mem [TABLE_DEPTH];

  logic [15:0]                in_len;
  logic [15:0]                in_etype;
  logic [7:0]                 in_proto;
  logic [ipff_pkg::KEY_W-1:0] in_key;
  logic                       early;
  logic                       early_verdict;
  logic [2:0]                 early_cause;

  logic [ipff_pkg::THR_W-1:0]   thr_r;
  logic [ipff_pkg::KEY_W-1:0]   key_r;
  logic [USED_W-1:0]            used_r;
  logic [USED_W-1:0]            addr_r;
  logic [IDX_W-1:0]             rd_idx_r;
  logic                         rd_pend_r;
  logic [ipff_pkg::KEY_W-1:0]   key_rd_r;
  logic [COUNT_WIDTH-1:0]       cnt_rd_r;
  logic [IDX_W-1:0]             hit_idx_r;
  logic [COUNT_WIDTH-1:0]       cnt_r;
  logic                         res_verdict_r;
  logic [2:0]                   res_cause_r;
  logic [ipff_pkg::RES_CNT_W-1:0] res_cnt_r;
  logic                         out_valid_r;
  logic                         out_verdict_r;
  logic [2:0]                   out_cause_r;
  logic [ipff_pkg::RES_CNT_W-1:0] out_cnt_r;

  logic                   full;
  logic                   match;
  logic                   issue_ok;
  logic                   rd_en;
  logic                   key_we;
  logic                   cnt_we;
  logic [IDX_W-1:0]       wr_idx;
  logic [COUNT_WIDTH-1:0] wr_cnt;
  logic [COUNT_WIDTH-1:0] cnt_sat;
  logic [CMP_W-1:0]       cnt_ext;
  logic [CMP_W-1:0]       thr_ext;
  logic                   over;

  assign in_len   = in_tdata[15:0];
  assign in_etype = in_tdata[31:16];
  assign in_proto = in_tdata[39:32];
  assign in_key   = in_tdata[71:40];

  always_comb begin
    early         = 1'b1;
    early_verdict = ipff_pkg::VERDICT_DROP;
    early_cause   = ipff_pkg::CAUSE_TRUNCATED;
    if (in_len < ipff_pkg::LEN_ETH) begin
      early_verdict = ipff_pkg::VERDICT_DROP;
    end else if (in_etype != ipff_pkg::ETYPE_IPV4) begin
      early_verdict = ipff_pkg::VERDICT_PASS;
      early_cause   = ipff_pkg::CAUSE_NOT_ICMP;
    end else if (in_len < ipff_pkg::LEN_ETH_IP) begin
      early_verdict = ipff_pkg::VERDICT_DROP;
    end else if (in_proto != ipff_pkg::PROTO_ICMP) begin
      early_verdict = ipff_pkg::VERDICT_PASS;
      early_cause   = ipff_pkg::CAUSE_NOT_ICMP;
    end else if (in_len < ipff_pkg::LEN_ETH_IP_ICMP) begin
      early_verdict = ipff_pkg::VERDICT_DROP;
    end else begin
      early = 1'b0;
    end
  end

  assign full     = (used_r == USED_W'(TABLE_DEPTH));
  assign match    = rd_pend_r && (key_rd_r == key_r);
  assign issue_ok = (addr_r < used_r);
  assign rd_en    = cmd.scan && !match && issue_ok;
  assign key_we   = cmd.miss && !full;
  assign cnt_we   = cmd.hit_upd || (cmd.miss && !full);
  assign wr_idx   = cmd.hit_upd ? hit_idx_r : used_r[IDX_W-1:0];
  assign wr_cnt   = cmd.hit_upd ? cnt_r : COUNT_WIDTH'(1);
  assign cnt_sat  = (&cnt_rd_r) ? cnt_rd_r : cnt_rd_r + COUNT_WIDTH'(1);
  assign cnt_ext  = CMP_W'(cnt_r);
  assign thr_ext  = CMP_W'(thr_r);
  assign over     = (cnt_ext > thr_ext);

  assign status.early    = early;
  assign status.match    = match;
  assign status.issue_ok = issue_ok;
  assign status.rd_pend  = rd_pend_r;
  assign status.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_idx] <= key_r;
    end
    if (rd_en) begin
      key_rd_r <= key_mem[addr_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[wr_idx] <= wr_cnt;
    end
    if (rd_en) begin
      cnt_rd_r <= cnt_mem[addr_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= ipff_pkg::DROP_THRESHOLD_RST;
      used_r      <= '0;
      addr_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (cmd.load) begin
        addr_r    <= '0;
        rd_pend_r <= 1'b0;
      end else if (cmd.scan && !match) begin
        rd_pend_r <= issue_ok;
        if (issue_ok) begin
          addr_r <= addr_r + USED_W'(1);
        end
      end
      if (key_we) begin
        used_r <= used_r + USED_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r         <= in_key;
      res_verdict_r <= early_verdict;
      res_cause_r   <= early_cause;
      res_cnt_r     <= '0;
    end
    if (rd_en) begin
      rd_idx_r <= addr_r[IDX_W-1:0];
    end
    if (cmd.scan && match) begin
      hit_idx_r <= rd_idx_r;
      cnt_r     <= cnt_sat;
    end
    if (cmd.hit_upd) begin
      res_verdict_r <= over ? ipff_pkg::VERDICT_DROP : ipff_pkg::VERDICT_PASS;
      res_cause_r   <= over ? ipff_pkg::CAUSE_OVER_THR : ipff_pkg::CAUSE_UNDER_THR;
      res_cnt_r     <= cnt_ext[ipff_pkg::RES_CNT_W-1:0];
    end
    if (cmd.miss) begin
      res_verdict_r <= ipff_pkg::VERDICT_PASS;
      res_cause_r   <= full ? ipff_pkg::CAUSE_TABLE_FULL : ipff_pkg::CAUSE_NEW_SOURCE;
      res_cnt_r     <= full ? '0 : ipff_pkg::RES_CNT_W'(1);
    end
    if (cmd.emit) begin
      out_verdict_r <= res_verdict_r;
      out_cause_r   <= res_cause_r;
      out_cnt_r     <= res_cnt_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_cnt_r, out_cause_r, out_verdict_r};

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(TABLE_DEPTH))
    else $error("table fill count beyond the table depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> addr_r <= used_r)
    else $error("probe address ran past the filled entries");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.miss && !full |=> used_r == $past(used_r) + USED_W'(1))
    else $error("insertion did not advance the fill count");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_tdata))
    else $error("held result was overwritten");
`endif

endmodule

// File: rtl/icmp_source_flood_filter.sv
// Per-source ICMP flood filter. Each request on the in_ channel summarises
// one frame; the out_ channel returns exactly one verdict request per input
// request, in order. The drop threshold resets to 20; the user must write it
// through cfg_we/cfg_wdata while the block is idle; it does not enforce this.
// Frames that are short, not IPv4 or not ICMP are judged from the header
// fields alone; their result waits in the emit state for a free output
// register, and the next request is taken once it has been emitted.
// ICMP frames probe the source table one entry per cycle through the single
// read port of the key memory. A hit ends the scan at the matching entry; a
// new or untracked source is known once every entry in use has been probed.
// Entries fill in order and never expire, so the fill count marks the
// valid entries and no clearing pass is needed after reset.
// Synchronous active-low reset empties the table, drops any pending result
// and restores the threshold. A stalled receiver holds the result in the
// output register; one further request may be accepted and worked on, and
// it then waits until the output register is free.
module icmp_source_flood_filter #(
  parameter int TABLE_DEPTH = ipff_pkg::TABLE_DEPTH_DEF,
  parameter int COUNT_WIDTH = ipff_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // frame_length[15:0], ether_type[31:16], ip_protocol[39:32],
  // source_address[71:40]
  input  logic [ipff_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // verdict[0], verdict_cause[3:1], source_count[35:4], zero[39:36]
  output logic [ipff_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [ipff_pkg::THR_W-1:0]      cfg_wdata
);

  ipff_pkg::cmd_t    cmd;
  ipff_pkg::status_t status;

  ipff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ipff_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

// File: tb/testbench.sv
module testbench;
  import ipff_pkg::*;

  localparam int TABLE_SIZE  = TABLE_DEPTH_DEF;
  localparam int STALL_LIMIT = 50000;
  localparam int PHASE_ITEMS = 16;
  localparam int PROBE_ROWS  = 22;

  typedef struct packed {
    logic [31:0] source_address;
    logic [7:0]  ip_protocol;
    logic [15:0] ether_type;
    logic [15:0] frame_length;
  } frame_t;

  typedef struct packed {
    logic [3:0]  padding;
    logic [31:0] source_count;
    logic [2:0]  verdict_cause;
    logic        verdict;
  } verdict_t;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic        typed;
    logic        verdict;
    logic [2:0]  verdict_cause;
    logic [31:0] source_count;
  } probe_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [THR_W-1:0]      cfg_wdata  = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic [31:0] drop_limit = DROP_THRESHOLD_RST;
  logic [31:0] source_keys [TABLE_SIZE];
  logic [31:0] source_counts [TABLE_SIZE];
  int          sources_tracked = 0;
  verdict_t    pending_verdicts [$];
  logic [31:0] key_pool [$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          quiet_left [2] = '{0, 0};

  // The threshold is 20 after reset, so every typed row below can be read off directly.
  probe_row_t probe_rows [PROBE_ROWS] = '{
    '{16'd0,    ETYPE_IPV4, PROTO_ICMP, 32'h0000_0000, 1'b1, VERDICT_DROP, CAUSE_TRUNCATED, 32'd0},
    '{16'd13,   ETYPE_IPV4, PROTO_ICMP, 32'h0000_0000, 1'b1, VERDICT_DROP, CAUSE_TRUNCATED, 32'd0},
    '{16'd13,   16'h0000,   8'h00,      32'hFFFF_FFFF, 1'b1, VERDICT_DROP, CAUSE_TRUNCATED, 32'd0},
    '{16'd14,   16'h86DD,   PROTO_ICMP, 32'h0000_0000, 1'b1, VERDICT_PASS, CAUSE_NOT_ICMP,  32'd0},
    '{16'hFFFF, 16'hFFFF,   8'hFF,      32'hFFFF_FFFF, 1'b1, VERDICT_PASS, CAUSE_NOT_ICMP,  32'd0},
    '{16'd14,   ETYPE_IPV4, PROTO_ICMP, 32'h0000_0000, 1'b1, VERDICT_DROP, CAUSE_TRUNCATED, 32'd0},
    '{16'd33,   ETYPE_IPV4, PROTO_ICMP, 32'h0000_0000, 1'b1, VERDICT_DROP, CAUSE_TRUNCATED, 32'd0},
    '{16'd34,   ETYPE_IPV4, 8'd6,       32'h0000_0000, 1'b1, VERDICT_PASS, CAUSE_NOT_ICMP,  32'd0},
    '{16'hFFFF, ETYPE_IPV4, 8'hFF,      32'h0000_0000, 1'b1, VERDICT_PASS, CAUSE_NOT_ICMP,  32'd0},
    '{16'd34,   ETYPE_IPV4, PROTO_ICMP, 32'h0000_0000, 1'b1, VERDICT_DROP, CAUSE_TRUNCATED, 32'd0},
    '{16'd41,   ETYPE_IPV4, PROTO_ICMP, 32'hFFFF_FFFF, 1'b1, VERDICT_DROP, CAUSE_TRUNCATED, 32'd0},
    '{16'd42,   ETYPE_IPV4, PROTO_ICMP, 32'h0000_0000, 1'b1, VERDICT_PASS, CAUSE_NEW_SOURCE, 32'd1},
    '{16'hFFFF, ETYPE_IPV4, PROTO_ICMP, 32'hFFFF_FFFF, 1'b1, VERDICT_PASS, CAUSE_NEW_SOURCE, 32'd1},
    '{16'd42,   ETYPE_IPV4, PROTO_ICMP, 32'h0000_0000, 1'b1, VERDICT_PASS, CAUSE_UNDER_THR, 32'd2},
    '{16'd64,   ETYPE_IPV4, PROTO_ICMP, 32'hFFFF_FFFF, 1'b1, VERDICT_PASS, CAUSE_UNDER_THR, 32'd2},
    '{16'd98,   ETYPE_IPV4, PROTO_ICMP, 32'h0A00_0001, 1'b1, VERDICT_PASS, CAUSE_NEW_SOURCE, 32'd1},
    '{16'd42,   16'h0801,   PROTO_ICMP, 32'h0000_0000, 1'b1, VERDICT_PASS, CAUSE_NOT_ICMP,  32'd0},
    '{16'd60,   ETYPE_IPV4, 8'h00,      32'h0000_0000, 1'b1, VERDICT_PASS, CAUSE_NOT_ICMP,  32'd0},
    '{16'd1500, ETYPE_IPV4, PROTO_ICMP, 32'h0A00_0001, 1'b0, VERDICT_PASS, CAUSE_NOT_ICMP,  32'd0},
    '{16'd1500, ETYPE_IPV4, PROTO_ICMP, 32'h0000_0000, 1'b0, VERDICT_PASS, CAUSE_NOT_ICMP,  32'd0},
    '{16'd74,   ETYPE_IPV4, PROTO_ICMP, 32'hC0A8_0001, 1'b0, VERDICT_PASS, CAUSE_NOT_ICMP,  32'd0},
    '{16'd42,   ETYPE_IPV4, PROTO_ICMP, 32'hC0A8_0001, 1'b0, VERDICT_PASS, CAUSE_NOT_ICMP,  32'd0}
  };

  icmp_source_flood_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic verdict_t judge_frame(frame_t f);
    verdict_t    v;
    logic [31:0] c;
    v = '0;
    if (f.frame_length < LEN_ETH) begin
      v.verdict = VERDICT_DROP;
      v.verdict_cause = CAUSE_TRUNCATED;
      return v;
    end
    if (f.ether_type != ETYPE_IPV4) begin
      v.verdict_cause = CAUSE_NOT_ICMP;
      return v;
    end
    if (f.frame_length < LEN_ETH_IP) begin
      v.verdict = VERDICT_DROP;
      v.verdict_cause = CAUSE_TRUNCATED;
      return v;
    end
    if (f.ip_protocol != PROTO_ICMP) begin
      v.verdict_cause = CAUSE_NOT_ICMP;
      return v;
    end
    if (f.frame_length < LEN_ETH_IP_ICMP) begin
      v.verdict = VERDICT_DROP;
      v.verdict_cause = CAUSE_TRUNCATED;
      return v;
    end
    for (int i = 0; i < sources_tracked; i++) begin
      if (source_keys[i] == f.source_address) begin
        c = source_counts[i];
        if (c != '1) c = c + 32'd1;
        source_counts[i] = c;
        v.source_count = c;
        if (c > drop_limit) begin
          v.verdict = VERDICT_DROP;
          v.verdict_cause = CAUSE_OVER_THR;
        end else begin
          v.verdict = VERDICT_PASS;
          v.verdict_cause = CAUSE_UNDER_THR;
        end
        return v;
      end
    end
    if (sources_tracked >= TABLE_SIZE) begin
      v.verdict = VERDICT_PASS;
      v.verdict_cause = CAUSE_TABLE_FULL;
      return v;
    end
    source_keys[sources_tracked] = f.source_address;
    source_counts[sources_tracked] = 32'd1;
    sources_tracked++;
    v.verdict = VERDICT_PASS;
    v.verdict_cause = CAUSE_NEW_SOURCE;
    v.source_count = 32'd1;
    return v;
  endfunction

  // Mostly random waits, with the odd stretch in which a side never idles.
  function int draw_wait(int side);
    if (quiet_left[side] > 0) begin
      quiet_left[side] = quiet_left[side] - 1;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      quiet_left[side] = int'($urandom_range(8, 40));
      return 0;
    end
    return int'($urandom_range(0, 18));
  endfunction

  function automatic logic [31:0] pick_source();
    int r;
    r = int'($urandom_range(0, 9));
    if (r < 8 && key_pool.size() > 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (r == 8 && sources_tracked > 0) return source_keys[$urandom_range(0, sources_tracked - 1)];
    return $urandom;
  endfunction

  function automatic frame_t icmp_frame(logic [31:0] key);
    frame_t f;
    if ($urandom_range(0, 7) == 0) f.frame_length = 16'($urandom_range(42, 65535));
    else f.frame_length = 16'($urandom_range(42, 1518));
    f.ether_type = ETYPE_IPV4;
    f.ip_protocol = PROTO_ICMP;
    f.source_address = key;
    return f;
  endfunction

  function automatic frame_t noise_frame();
    frame_t f;
    f = icmp_frame(pick_source());
    case ($urandom_range(0, 6))
      0, 1: begin
        f.frame_length = 16'($urandom);
        f.ether_type = 16'($urandom);
        f.ip_protocol = 8'($urandom);
        f.source_address = $urandom;
      end
      2: begin
        f.frame_length = 16'($urandom_range(0, 13));
        f.ether_type = 16'($urandom);
      end
      3: begin
        f.frame_length = 16'($urandom);
        f.ether_type = 16'($urandom);
        if (f.ether_type == ETYPE_IPV4) f.ether_type = ~ETYPE_IPV4;
      end
      4: begin
        f.frame_length = 16'($urandom_range(14, 33));
        f.ip_protocol = 8'($urandom);
      end
      5: begin
        f.frame_length = 16'($urandom_range(34, 65535));
        f.ip_protocol = 8'($urandom);
        if (f.ip_protocol == PROTO_ICMP) f.ip_protocol = 8'hFF;
      end
      default: f.frame_length = 16'($urandom_range(34, 41));
    endcase
    return f;
  endfunction

  task automatic send_frame(input frame_t f, input logic typed, input verdict_t want);
    int       gap;
    verdict_t predicted;
    in_tvalid <= 1'b1;
    in_tdata <= f;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = judge_frame(f);
    pending_verdicts.push_back(typed ? want : predicted);
    gap = draw_wait(0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input frame_t f);
    send_frame(f, 1'b0, '0);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  task automatic write_threshold(input logic [31:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    drop_limit = value;
  endtask

  initial begin
    frame_t      f;
    verdict_t    want;
    int          pause_at;
    logic [31:0] limit_value;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < PROBE_ROWS; r++) begin
      f.frame_length = probe_rows[r].frame_length;
      f.ether_type = probe_rows[r].ether_type;
      f.ip_protocol = probe_rows[r].ip_protocol;
      f.source_address = probe_rows[r].source_address;
      want = '0;
      want.verdict = probe_rows[r].verdict;
      want.verdict_cause = probe_rows[r].verdict_cause;
      want.source_count = probe_rows[r].source_count;
      send_frame(f, probe_rows[r].typed, want);
    end

    // A small pool of sources per phase keeps the table short and pushes
    // counts across the threshold.
    for (int p = 0; p < 6; p++) begin
      case (p)
        1: limit_value = 32'd0;
        2: limit_value = 32'hFFFF_FFFF;
        3: limit_value = 32'd1;
        4: limit_value = $urandom_range(0, 30);
        default: limit_value = $urandom;
      endcase
      if (p > 0) write_threshold(limit_value);
      key_pool.delete();
      repeat ((p == 0) ? 4 : $urandom_range(3, 16)) key_pool.push_back($urandom);
      pause_at = int'($urandom_range(2, PHASE_ITEMS - 2));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == pause_at) drain_results();
        if ($urandom_range(0, 3) != 0) send_random(icmp_frame(pick_source()));
        else send_random(noise_frame());
      end
    end

    // Fill the source table to its last entry.
    write_threshold(32'd3);
    key_pool.delete();
    while (sources_tracked < TABLE_SIZE) begin
      send_random(icmp_frame($urandom));
    end

    for (int p = 0; p < 2; p++) begin
      write_threshold((p == 0) ? $urandom_range(0, 8) : $urandom);
      repeat (10) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: send_random(icmp_frame($urandom));
          4, 5, 6, 7: send_random(icmp_frame(source_keys[$urandom_range(0, TABLE_SIZE - 1)]));
          default: send_random(noise_frame());
        endcase
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    int       stall;
    verdict_t got;
    verdict_t want;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait(1);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got = out_tdata;
      if (pending_verdicts.size() == 0) begin
        $error("verdict request arrived with nothing outstanding: %0h", got);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.verdict !== want.verdict) begin
          $error("verdict: expected %0h, got %0h", want.verdict, got.verdict);
          error_count++;
        end
        if (got.verdict_cause !== want.verdict_cause) begin
          $error("verdict_cause: expected %0h, got %0h", want.verdict_cause, got.verdict_cause);
          error_count++;
        end
        if (got.source_count !== want.source_count) begin
          $error("source_count: expected %0h, got %0h", want.source_count, got.source_count);
          error_count++;
        end
        if (got.padding !== 4'd0) begin
          $error("padding: expected %0h, got %0h", 4'd0, got.padding);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
